FILE: design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helper functions of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_PAGES   = 16384;
   localparam int LEVELS      = $clog2(MAX_PAGES);
   localparam int SIZE_W      = LEVELS + 1;
   localparam int NODE_W      = LEVELS + 1;
   localparam int WORD_W      = LEVELS;
   localparam int WORD_DEPTH  = MAX_PAGES - 1;
   localparam int PAIR_W      = 2 * SIZE_W;

   localparam int OPCODE_W    = 1;
   localparam int PAGES_W     = 15;
   localparam int OFFSET_W    = 14;
   localparam int STATUS_W    = 2;
   localparam int POOL_W      = 15;
   localparam int N_W         = PAGES_W + 1;

   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_POOL_PAGES = CSR_ADDR_W'(0);
   localparam logic [POOL_W-1:0]     POOL_RESET      = POOL_W'(16384);

   localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE       = 2'd0,
      STS_NO_ROOM    = 2'd1,
      STS_BAD_OFFSET = 2'd2
   } status_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [PAGES_W-1:0]  request_pages;
      logic [OFFSET_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] granted_offset;
      logic [PAGES_W-1:0]  block_pages;
      logic [PAGES_W-1:0]  free_left;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_FILL,
      ST_IDLE,
      ST_START,
      ST_DESCEND,
      ST_CLIMB,
      ST_ASCEND,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic init;
      logic fill;
      logic accept;
      logic start;
      logic descend;
      logic climb;
      logic ascend;
   } cmd_type;

   typedef struct packed {
      logic fill_done;
      logic is_free;
      logic fail;
      logic whole_pool;
      logic descend_done;
      logic climb_found;
      logic climb_miss;
      logic at_root;
   } stat_type;

   // clamp to MAX_PAGES, then keep the highest set bit
   function automatic logic [SIZE_W-1:0] pool_round(input logic [POOL_W-1:0] pages);
      logic [POOL_W-1:0] clamped;
      logic [SIZE_W-1:0] result;
      clamped = (pages > POOL_W'(MAX_PAGES)) ? POOL_W'(MAX_PAGES) : pages;
      result  = '0;
      for (int i = 0; i < POOL_W; i++) begin
         if (clamped[i]) begin
            result = SIZE_W'(1) << i;
         end
      end
      return result;
   endfunction

   // next power of two at or above the request; zero counts as one
   function automatic logic [N_W-1:0] round_up(input logic [PAGES_W-1:0] pages);
      logic [PAGES_W-1:0] less;
      logic [N_W-1:0]     result;
      less   = pages - PAGES_W'(1);
      result = N_W'(1);
      if (pages > PAGES_W'(1)) begin
         for (int i = 0; i < PAGES_W; i++) begin
            if (less[i]) begin
               result = N_W'(2) << i;
            end
         end
      end
      return result;
   endfunction

endpackage

FILE: design/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bpa_csr.sv
// ----------------------------------------------------------------------------
// bpa_csr
// Register port: holds the pool size register and flags writes to it.
// ----------------------------------------------------------------------------
module bpa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [bpa_pkg::POOL_W-1:0]       pool_pages,
   output logic                             csr_write
);

   logic [bpa_pkg::POOL_W-1:0] pool_pages_ff;
   logic [bpa_pkg::POOL_W-1:0] pool_pages_in;
   logic                       hit;

   assign hit       = (paddr == bpa_pkg::ADDR_POOL_PAGES);
   assign csr_write = psel && penable && pwrite && hit;
   assign pready    = 1'b1;

   always_comb begin
      pool_pages_in = pool_pages_ff;
      if (csr_write) begin
         pool_pages_in = pwdata[bpa_pkg::POOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_pages_ff <= bpa_pkg::POOL_RESET;
      end else begin
         pool_pages_ff <= pool_pages_in;
      end
   end

   assign prdata     = hit ? bpa_pkg::CSR_DATA_W'(pool_pages_ff) : '0;
   assign pool_pages = pool_pages_ff;

endmodule

FILE: design/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: tree rebuild, request intake, descent, climb, ascent, response.
// ----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               csr_write,
   input  bpa_pkg::stat_type  stat,
   output bpa_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);

   bpa_pkg::state_type state_ff;
   bpa_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      if (csr_write) begin
         state_in = bpa_pkg::ST_INIT;
      end else begin
         case (state_ff)
            bpa_pkg::ST_INIT: begin
               state_in = bpa_pkg::ST_FILL;
            end
            bpa_pkg::ST_FILL: begin
               if (stat.fill_done) begin
                  state_in = bpa_pkg::ST_IDLE;
               end
            end
            bpa_pkg::ST_IDLE: begin
               if (start) begin
                  state_in = bpa_pkg::ST_START;
               end
            end
            bpa_pkg::ST_START: begin
               if (stat.fail) begin
                  state_in = bpa_pkg::ST_RESPOND;
               end else if (stat.is_free) begin
                  state_in = bpa_pkg::ST_CLIMB;
               end else if (stat.whole_pool) begin
                  state_in = bpa_pkg::ST_ASCEND;
               end else begin
                  state_in = bpa_pkg::ST_DESCEND;
               end
            end
            bpa_pkg::ST_DESCEND: begin
               if (stat.descend_done) begin
                  state_in = bpa_pkg::ST_ASCEND;
               end
            end
            bpa_pkg::ST_CLIMB: begin
               if (stat.climb_found) begin
                  state_in = bpa_pkg::ST_ASCEND;
               end else if (stat.climb_miss) begin
                  state_in = bpa_pkg::ST_RESPOND;
               end
            end
            bpa_pkg::ST_ASCEND: begin
               if (stat.at_root) begin
                  state_in = bpa_pkg::ST_RESPOND;
               end
            end
            bpa_pkg::ST_RESPOND: begin
               state_in = bpa_pkg::ST_IDLE;
            end
            default: begin
               state_in = bpa_pkg::ST_INIT;
            end
         endcase
      end
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         bpa_pkg::ST_INIT: begin
            cmd.init = 1'b1;
         end
         bpa_pkg::ST_FILL: begin
            cmd.fill = 1'b1;
         end
         bpa_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         bpa_pkg::ST_START: begin
            cmd.start = 1'b1;
         end
         bpa_pkg::ST_DESCEND: begin
            cmd.descend = 1'b1;
         end
         bpa_pkg::ST_CLIMB: begin
            cmd.climb = 1'b1;
         end
         bpa_pkg::ST_ASCEND: begin
            cmd.ascend = 1'b1;
         end
         bpa_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: longest-run tree in a sibling-pair RAM, root register, free count,
// request registers and the per-level descent, climb and merge logic.
// ----------------------------------------------------------------------------
module bpa_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  bpa_pkg::cmd_type             cmd,
   output bpa_pkg::stat_type            stat,
   input  bpa_pkg::req_type             req_data,
   input  logic [bpa_pkg::POOL_W-1:0]   pool_pages,
   output bpa_pkg::rsp_type             rsp_data
);

   localparam int SIZE_W   = bpa_pkg::SIZE_W;
   localparam int NODE_W   = bpa_pkg::NODE_W;
   localparam int WORD_W   = bpa_pkg::WORD_W;
   localparam int PAIR_W   = bpa_pkg::PAIR_W;
   localparam int N_W      = bpa_pkg::N_W;
   localparam int OFFSET_W = bpa_pkg::OFFSET_W;

   logic [SIZE_W-1:0]       pool_size_ff, pool_size_in;
   logic [SIZE_W-1:0]       root_ff, root_in;
   logic [SIZE_W-1:0]       free_ff, free_in;
   logic [WORD_W-1:0]       fill_w_ff, fill_w_in;
   logic [SIZE_W-1:0]       fill_cs_ff, fill_cs_in;
   logic                    op_ff, op_in;
   logic [N_W-1:0]          n_ff, n_in;
   logic [OFFSET_W-1:0]     offset_ff, offset_in;
   logic [NODE_W-1:0]       node_ff, node_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [SIZE_W-1:0]       val_ff, val_in;
   logic [OFFSET_W-1:0]     granted_ff, granted_in;
   logic [SIZE_W-1:0]       pages_ff, pages_in;
   bpa_pkg::status_type     status_ff, status_in;

   logic                    wr_en;
   logic [WORD_W-1:0]       wr_addr;
   logic [PAIR_W-1:0]       wr_data;
   logic [WORD_W-1:0]       rd_addr;
   logic [PAIR_W-1:0]       rd_data;

   logic [SIZE_W-1:0]       rounded_pool;
   logic [SIZE_W-1:0]       rd_left, rd_right;
   logic [NODE_W-1:0]       node_dec;
   logic [WORD_W-1:0]       parent_node;
   logic [WORD_W-1:0]       parent_dec;
   logic [WORD_W-1:0]       grand_word;
   logic [SIZE_W-1:0]       node_val;
   logic [NODE_W-1:0]       leaf;
   logic [NODE_W-1:0]       leaf_dec;
   logic [WORD_W-1:0]       leaf_word;
   logic                    is_free;
   logic                    alloc_fail, free_fail, fail;
   logic [SIZE_W-1:0]       half;
   logic                    go_left;
   logic [NODE_W-1:0]       child;
   logic                    descend_done;
   logic [PAIR_W-1:0]       new_pair;
   logic [SIZE_W-1:0]       new_left, new_right;
   logic [SIZE_W:0]         psize, pair_sum;
   logic [SIZE_W-1:0]       merged;
   logic                    climb_found, at_root;
   logic [WORD_W:0]         fill_next1, fill_next2;
   logic                    fill_halve, fill_done;

   bpa_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (bpa_pkg::WORD_DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word k holds the children of node k: right in the upper half
   assign rd_left     = rd_data[SIZE_W-1:0];
   assign rd_right    = rd_data[PAIR_W-1:SIZE_W];
   assign rounded_pool = bpa_pkg::pool_round(pool_pages);

   assign node_dec    = node_ff - NODE_W'(1);
   assign parent_node = node_dec[NODE_W-1:1];
   assign parent_dec  = parent_node - WORD_W'(1);
   assign grand_word  = {1'b0, parent_dec[WORD_W-1:1]};
   assign at_root     = (node_ff == '0);
   assign node_val    = at_root ? root_ff : (node_ff[0] ? rd_left : rd_right);

   assign leaf        = NODE_W'(offset_ff) + NODE_W'(pool_size_ff) - NODE_W'(1);
   assign leaf_dec    = leaf - NODE_W'(1);
   assign leaf_word   = leaf_dec[NODE_W-1:1];

   assign is_free     = (op_ff == bpa_pkg::OP_FREE);
   assign alloc_fail  = (pool_size_ff == '0) || (n_ff > N_W'(pool_size_ff))
                        || (N_W'(root_ff) < n_ff);
   assign free_fail   = (SIZE_W'(offset_ff) >= pool_size_ff);
   assign fail        = is_free ? free_fail : alloc_fail;

   assign half         = size_ff >> 1;
   assign go_left      = (N_W'(rd_left) >= n_ff)
                         && ((N_W'(rd_right) < n_ff) || (rd_left <= rd_right));
   assign child        = {node_ff[NODE_W-2:0], 1'b0} + (go_left ? NODE_W'(1) : NODE_W'(2));
   assign descend_done = (N_W'(half) == n_ff);

   assign new_pair  = node_ff[0] ? {rd_right, val_ff} : {val_ff, rd_left};
   assign new_left  = new_pair[SIZE_W-1:0];
   assign new_right = new_pair[PAIR_W-1:SIZE_W];
   assign psize     = {size_ff, 1'b0};
   assign pair_sum  = (SIZE_W+1)'(new_left) + (SIZE_W+1)'(new_right);
   assign merged    = (pair_sum == psize) ? psize[SIZE_W-1:0]
                      : ((new_left > new_right) ? new_left : new_right);

   assign climb_found = (node_val == '0);

   assign fill_next1 = (WORD_W+1)'(fill_w_ff) + (WORD_W+1)'(1);
   assign fill_next2 = (WORD_W+1)'(fill_w_ff) + (WORD_W+1)'(2);
   assign fill_halve = ((fill_next2 & fill_next1) == '0);
   assign fill_done  = ((SIZE_W+1)'(fill_next2) >= (SIZE_W+1)'(pool_size_ff));

   always_comb begin
      stat              = '0;
      stat.fill_done    = fill_done;
      stat.is_free      = is_free;
      stat.fail         = fail;
      stat.whole_pool   = (n_ff == N_W'(pool_size_ff));
      stat.descend_done = descend_done;
      stat.climb_found  = climb_found;
      stat.climb_miss   = !climb_found && at_root;
      stat.at_root      = at_root;
   end

   always_comb begin
      if (cmd.start) begin
         rd_addr = is_free ? leaf_word : '0;
      end else if (cmd.descend) begin
         rd_addr = descend_done ? node_ff[WORD_W-1:0] : child[WORD_W-1:0];
      end else if (cmd.climb) begin
         rd_addr = climb_found ? parent_node : grand_word;
      end else begin
         rd_addr = grand_word;
      end
   end

   always_comb begin
      if (cmd.fill) begin
         wr_en   = (pool_size_ff > SIZE_W'(1));
         wr_addr = fill_w_ff;
         wr_data = {fill_cs_ff, fill_cs_ff};
      end else begin
         wr_en   = cmd.ascend && !at_root;
         wr_addr = parent_node;
         wr_data = new_pair;
      end
   end

   always_comb begin
      pool_size_in = pool_size_ff;
      root_in      = root_ff;
      free_in      = free_ff;
      fill_w_in    = fill_w_ff;
      fill_cs_in   = fill_cs_ff;
      op_in        = op_ff;
      n_in         = n_ff;
      offset_in    = offset_ff;
      node_in      = node_ff;
      size_in      = size_ff;
      val_in       = val_ff;
      granted_in   = granted_ff;
      pages_in     = pages_ff;
      status_in    = status_ff;

      if (cmd.init) begin
         pool_size_in = rounded_pool;
         root_in      = rounded_pool;
         free_in      = rounded_pool;
         fill_w_in    = '0;
         fill_cs_in   = rounded_pool >> 1;
      end

      if (cmd.fill) begin
         fill_w_in = fill_next1[WORD_W-1:0];
         if (fill_halve) begin
            fill_cs_in = fill_cs_ff >> 1;
         end
      end

      if (cmd.accept) begin
         op_in     = req_data.opcode;
         n_in      = bpa_pkg::round_up(req_data.request_pages);
         offset_in = req_data.block_offset;
      end

      if (cmd.start) begin
         granted_in = '0;
         pages_in   = '0;
         val_in     = '0;
         node_in    = '0;
         size_in    = pool_size_ff;
         if (fail) begin
            status_in = is_free ? bpa_pkg::STS_BAD_OFFSET : bpa_pkg::STS_NO_ROOM;
         end else begin
            status_in = bpa_pkg::STS_DONE;
            if (is_free) begin
               node_in = leaf;
               size_in = SIZE_W'(1);
            end else begin
               free_in  = free_ff - SIZE_W'(n_ff);
               pages_in = SIZE_W'(n_ff);
            end
         end
      end

      if (cmd.descend) begin
         node_in = child;
         size_in = half;
         if (!go_left) begin
            granted_in = granted_ff + OFFSET_W'(half);
         end
      end

      if (cmd.climb) begin
         if (climb_found) begin
            val_in   = size_ff;
            free_in  = free_ff + size_ff;
            pages_in = size_ff;
         end else if (!at_root) begin
            node_in = NODE_W'(parent_node);
            size_in = size_ff << 1;
         end else begin
            status_in = bpa_pkg::STS_BAD_OFFSET;
         end
      end

      if (cmd.ascend) begin
         if (at_root) begin
            root_in = val_ff;
         end else begin
            node_in = NODE_W'(parent_node);
            size_in = psize[SIZE_W-1:0];
            val_in  = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= '0;
         root_ff      <= '0;
         free_ff      <= '0;
      end else begin
         pool_size_ff <= pool_size_in;
         root_ff      <= root_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_w_ff  <= fill_w_in;
      fill_cs_ff <= fill_cs_in;
      op_ff      <= op_in;
      n_ff       <= n_in;
      offset_ff  <= offset_in;
      node_ff    <= node_in;
      size_ff    <= size_in;
      val_ff     <= val_in;
      granted_ff <= granted_in;
      pages_ff   <= pages_in;
      status_ff  <= status_in;
   end

   always_comb begin
      rsp_data                = '0;
      rsp_data.status         = status_ff;
      rsp_data.granted_offset = granted_ff;
      rsp_data.block_pages    = bpa_pkg::PAGES_W'(pages_ff);
      rsp_data.free_left      = bpa_pkg::PAGES_W'(free_ff);
   end

`ifndef SYNTHESIS
   a_free_le_pool: assert property (@(posedge clock) disable iff (reset)
      free_ff <= pool_size_ff)
      else $error("free count above pool size");

   a_root_le_pool: assert property (@(posedge clock) disable iff (reset)
      root_ff <= pool_size_ff)
      else $error("root run above pool size");

   a_descend_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.descend |-> ((N_W'(rd_left) >= n_ff) || (N_W'(rd_right) >= n_ff)))
      else $error("descent reached a node with no fitting child");

   a_size_pow2: assert property (@(posedge clock) disable iff (reset)
      (cmd.descend || cmd.climb || cmd.ascend) |-> $onehot(size_ff))
      else $error("node size not a power of two");
`endif

endmodule

FILE: design/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary-tree buddy allocator over a power-of-two pool of pages.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_data and raise start; the beat is taken on a
//    clock edge with start high and busy low. opcode 0 allocates, 1 frees.
//  - Response channel: rsp_valid is high for exactly one cycle with rsp_data;
//    the receiver cannot stall, so it must sample in that cycle.
//  - One operation at a time. A refused request goes straight to the
//    response beat. busy drops in the cycle after the response. The pace is
//    set by the tree RAM: one read per level on the way down or up, and one
//    read plus one write per level while merging toward the root.
//  - Register pool_pages at byte address 0 (APB, pready always high). A write
//    rebuilds the tree with all pages free.
//  - Reset and every pool_pages write start a rebuild that writes one tree
//    word per cycle; busy stays high until it finishes. The reset pool size
//    is 16384 pages.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  bpa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output bpa_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   logic [bpa_pkg::POOL_W-1:0] pool_pages;
   logic                       csr_write;
   bpa_pkg::cmd_type           cmd;
   bpa_pkg::stat_type          stat;

   bpa_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .pool_pages (pool_pages),
      .csr_write  (csr_write)
   );

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_write (csr_write),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .pool_pages (pool_pages),
      .rsp_data   (rsp_data)
   );

endmodule
